### design/gsr_pkg.sv
// Shared types, constants and helpers of the gather segment send ring.
package gsr_pkg;

  localparam int RING_SLOTS   = 16;
  localparam int HEADER_BYTES = 16;
  localparam int MAX_RESULTS  = 48;
  localparam int SLOT_W       = $clog2(RING_SLOTS);
  localparam int PTR_W        = $clog2(RING_SLOTS) + 1;
  localparam int CNT_W        = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QIDX_W       = $clog2(QUEUE_DEPTH);

  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(2 * RING_SLOTS - 1);
  localparam logic [PTR_W:0]   PTR_SPAN  = (PTR_W + 1)'(2 * RING_SLOTS);
  localparam logic [PTR_W:0]   SLOTS_CNT = (PTR_W + 1)'(RING_SLOTS);
  localparam logic [31:0]      HDR_BYTES = 32'(HEADER_BYTES);

  localparam logic [1:0] MODE_OFFER   = 2'd0;
  localparam logic [1:0] MODE_GATHER  = 2'd1;
  localparam logic [1:0] MODE_CONSUME = 2'd2;
  localparam logic [1:0] MODE_CLEAR   = 2'd3;

  localparam logic [2:0] RES_ACCEPTED = 3'd0;
  localparam logic [2:0] RES_FULL     = 3'd1;
  localparam logic [2:0] RES_SEGMENT  = 3'd2;
  localparam logic [2:0] RES_RELEASED = 3'd3;
  localparam logic [2:0] RES_EMPTY    = 3'd4;
  localparam logic [2:0] RES_DONE     = 3'd5;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] frame_tag;
    logic [31:0] bytes_sent;
    logic [23:0] control_len;
    logic [23:0] data_len;
    logic [31:0] written_bytes;
  } req_t;

  typedef struct packed {
    logic [23:0] start;
    logic [23:0] remaining;
  } seg_t;

  typedef struct packed {
    logic [15:0]     tag;
    seg_t [2:0]      seg;
  } slot_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [15:0] tag;
    logic [1:0]  segment_kind;
    logic [23:0] segment_start;
    logic [23:0] segment_len;
    logic [31:0] leftover;
    logic        last;
  } res_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [SLOT_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] s;
    s = (p >= PTR_W'(RING_SLOTS)) ? p - PTR_W'(RING_SLOTS) : p;
    ptr_slot = s[SLOT_W-1:0];
  endfunction

endpackage

### design/gsr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/gsr_front.sv
// Request queue that parts the input channel from the slot engine.
module gsr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  gsr_pkg::req_t in_req,
  output logic          req_valid,
  input  logic          req_take,
  output gsr_pkg::req_t req
);

  gsr_pkg::req_t                 entry [gsr_pkg::QUEUE_DEPTH];
  logic [gsr_pkg::QIDX_W-1:0]    wr_idx;
  logic [gsr_pkg::QIDX_W-1:0]    rd_idx;
  logic [gsr_pkg::QIDX_W:0]      count;
  logic                          push;
  logic                          pop;

  assign in_ready  = (count != (gsr_pkg::QIDX_W + 1)'(gsr_pkg::QUEUE_DEPTH));
  assign req_valid = (count != '0);
  assign req       = entry[rd_idx];
  assign push      = in_valid && in_ready;
  assign pop       = req_valid && req_take;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_idx] <= in_req;
    end
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= wr_idx + gsr_pkg::QIDX_W'(1);
      end
      if (pop) begin
        rd_idx <= rd_idx + gsr_pkg::QIDX_W'(1);
      end
      if (push && !pop) begin
        count <= count + (gsr_pkg::QIDX_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (gsr_pkg::QIDX_W + 1)'(1);
      end
    end
  end

endmodule

### design/gsr_engine.sv
// Slot engine: runs offer, gather, consume and clear requests against the ring.
module gsr_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_take,
  input  gsr_pkg::req_t req_in,
  output logic          out_valid,
  input  logic          out_ready,
  output gsr_pkg::res_t out_res
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_O1    = 4'd1;
  localparam logic [3:0] S_O2    = 4'd2;
  localparam logic [3:0] S_O3    = 4'd3;
  localparam logic [3:0] S_ONE   = 4'd4;
  localparam logic [3:0] S_GCHK  = 4'd5;
  localparam logic [3:0] S_GLD   = 4'd6;
  localparam logic [3:0] S_GSEG  = 4'd7;
  localparam logic [3:0] S_GEND  = 4'd8;
  localparam logic [3:0] S_CCHK  = 4'd9;
  localparam logic [3:0] S_CLD   = 4'd10;
  localparam logic [3:0] S_CSUM  = 4'd11;
  localparam logic [3:0] S_CDEC  = 4'd12;
  localparam logic [3:0] S_CREL  = 4'd13;
  localparam logic [3:0] S_CTRIM = 4'd14;
  localparam logic [3:0] S_CWB   = 4'd15;

  logic [3:0]                  state;
  gsr_pkg::req_t               req;
  logic [gsr_pkg::PTR_W-1:0]   head;
  logic [gsr_pkg::PTR_W-1:0]   tail;
  logic [gsr_pkg::PTR_W-1:0]   walk;
  logic [gsr_pkg::CNT_W-1:0]   n;
  logic [1:0]                  j;
  gsr_pkg::slot_t              work;
  logic [31:0]                 rem;
  logic [25:0]                 total;
  logic [31:0]                 off1;
  logic [31:0]                 off2;
  logic [24:0]                 hc;
  gsr_pkg::res_t               held;
  logic                        held_valid;
  gsr_pkg::res_t               res;
  logic [gsr_pkg::PTR_W:0]     pending;
  logic                        out_free;
  logic                        ram_we;
  logic [gsr_pkg::SLOT_W-1:0]  ram_raddr;
  gsr_pkg::slot_t              ram_wdata;
  gsr_pkg::slot_t              ram_rdata;
  gsr_pkg::seg_t               data_seg;
  gsr_pkg::seg_t               cur_seg;
  gsr_pkg::res_t               seg_res;
  gsr_pkg::res_t               res_init;
  gsr_pkg::res_t               out_next;
  logic                        out_load;

  assign pending  = (tail >= head) ? {1'b0, tail} - {1'b0, head}
                                   : {1'b0, tail} + gsr_pkg::PTR_SPAN - {1'b0, head};
  assign out_free = !out_valid || out_ready;
  assign req_take = (state == S_IDLE);
  assign cur_seg  = work.seg[j];

  always_comb begin
    data_seg = '0;
    if (off2 < {8'd0, req.data_len}) begin
      data_seg.start     = off2[23:0];
      data_seg.remaining = req.data_len - off2[23:0];
    end
    ram_wdata        = work;
    ram_wdata.seg[2] = (state == S_O3) ? data_seg : work.seg[2];
    ram_we           = (state == S_O3) || (state == S_CWB);
    ram_raddr        = gsr_pkg::ptr_slot((state == S_GCHK) ? walk : head);
    seg_res               = '0;
    seg_res.result_kind   = gsr_pkg::RES_SEGMENT;
    seg_res.tag           = work.tag;
    seg_res.segment_kind  = j;
    seg_res.segment_start = cur_seg.start;
    seg_res.segment_len   = cur_seg.remaining;
    // Single result: full for an offer (accepted after O3), done for a clear.
    res_init      = '0;
    res_init.last = 1'b1;
    if (req_in.mode == gsr_pkg::MODE_OFFER) begin
      res_init.result_kind = gsr_pkg::RES_FULL;
      res_init.tag         = req_in.frame_tag;
    end else if (req_in.mode == gsr_pkg::MODE_CLEAR) begin
      res_init.result_kind = gsr_pkg::RES_DONE;
    end
    out_load = 1'b0;
    out_next = res;
    unique case (state)
      S_ONE: begin
        out_load = out_free;
      end
      S_GSEG: begin
        out_load = out_free && held_valid && (cur_seg.remaining != '0);
        out_next = held;
      end
      S_GEND: begin
        out_load      = out_free && held_valid;
        out_next      = held;
        out_next.last = 1'b1;
      end
      S_CREL: begin
        out_load             = out_free;
        out_next             = '0;
        out_next.result_kind = gsr_pkg::RES_RELEASED;
        out_next.tag         = work.tag;
      end
      default: begin
      end
    endcase
  end

  gsr_ram #(
    .WIDTH($bits(gsr_pkg::slot_t)),
    .DEPTH(gsr_pkg::RING_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(gsr_pkg::ptr_slot(ram_we && state == S_O3 ? tail : head)),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_res <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      n          <= '0;
      held_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req        <= req_in;
            rem        <= req_in.written_bytes;
            walk       <= head;
            n          <= '0;
            held_valid <= 1'b0;
            res        <= res_init;
            unique case (req_in.mode)
              gsr_pkg::MODE_OFFER: begin
                if (pending >= gsr_pkg::SLOTS_CNT) begin
                  state <= S_ONE;
                end else begin
                  state <= S_O1;
                end
              end
              gsr_pkg::MODE_GATHER:  state <= S_GCHK;
              gsr_pkg::MODE_CONSUME: state <= S_CCHK;
              gsr_pkg::MODE_CLEAR: begin
                head  <= tail;
                state <= S_ONE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_O1: begin
          off1  <= (req.bytes_sent > gsr_pkg::HDR_BYTES)
                   ? req.bytes_sent - gsr_pkg::HDR_BYTES : '0;
          hc    <= 25'(gsr_pkg::HEADER_BYTES) + {1'b0, req.control_len};
          state <= S_O2;
        end
        S_O2: begin
          off2     <= (req.bytes_sent > {7'd0, hc})
                      ? req.bytes_sent - {7'd0, hc} : '0;
          work.tag <= req.frame_tag;
          if (req.bytes_sent < gsr_pkg::HDR_BYTES) begin
            work.seg[0].start     <= req.bytes_sent[23:0];
            work.seg[0].remaining <= gsr_pkg::HDR_BYTES[23:0] - req.bytes_sent[23:0];
          end else begin
            work.seg[0] <= '0;
          end
          if (off1 < {8'd0, req.control_len}) begin
            work.seg[1].start     <= off1[23:0];
            work.seg[1].remaining <= req.control_len - off1[23:0];
          end else begin
            work.seg[1] <= '0;
          end
          state <= S_O3;
        end
        S_O3: begin
          tail            <= gsr_pkg::ptr_next(tail);
          res.result_kind <= gsr_pkg::RES_ACCEPTED;
          res.tag         <= req.frame_tag;
          state           <= S_ONE;
        end
        S_ONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_GCHK: begin
          if (walk != tail && n <= gsr_pkg::CNT_W'(gsr_pkg::MAX_RESULTS - 3)) begin
            state <= S_GLD;
          end else begin
            state <= S_GEND;
          end
        end
        S_GLD: begin
          work  <= ram_rdata;
          j     <= 2'd0;
          state <= S_GSEG;
        end
        S_GSEG: begin
          // A found segment waits here while the previous one cannot leave.
          if (cur_seg.remaining == '0 || !held_valid || out_free) begin
            if (cur_seg.remaining != '0) begin
              held       <= seg_res;
              held_valid <= 1'b1;
              n          <= n + gsr_pkg::CNT_W'(1);
            end
            if (j == 2'd2) begin
              walk  <= gsr_pkg::ptr_next(walk);
              state <= S_GCHK;
            end else begin
              j <= j + 2'd1;
            end
          end
        end
        S_GEND: begin
          if (held_valid) begin
            if (out_free) begin
              held_valid <= 1'b0;
              state      <= S_IDLE;
            end
          end else begin
            head            <= tail;
            res.result_kind <= gsr_pkg::RES_EMPTY;
            state           <= S_ONE;
          end
        end
        S_CCHK: begin
          if (rem != '0 && head != tail
              && n < gsr_pkg::CNT_W'(gsr_pkg::MAX_RESULTS - 1)) begin
            state <= S_CLD;
          end else begin
            res.result_kind <= gsr_pkg::RES_DONE;
            res.leftover    <= rem;
            state           <= S_ONE;
          end
        end
        S_CLD: begin
          work  <= ram_rdata;
          state <= S_CSUM;
        end
        S_CSUM: begin
          total <= 26'(work.seg[0].remaining) + 26'(work.seg[1].remaining)
                   + 26'(work.seg[2].remaining);
          state <= S_CDEC;
        end
        S_CDEC: begin
          j <= 2'd0;
          if (rem >= {6'd0, total}) begin
            rem   <= rem - {6'd0, total};
            state <= S_CREL;
          end else begin
            state <= S_CTRIM;
          end
        end
        S_CREL: begin
          if (out_free) begin
            head  <= gsr_pkg::ptr_next(head);
            n     <= n + gsr_pkg::CNT_W'(1);
            state <= S_CCHK;
          end
        end
        S_CTRIM: begin
          // Segments are trimmed in order until the written bytes run out.
          if (rem != '0) begin
            if ({8'd0, cur_seg.remaining} <= rem) begin
              rem                     <= rem - {8'd0, cur_seg.remaining};
              work.seg[j].start       <= cur_seg.start + cur_seg.remaining;
              work.seg[j].remaining   <= '0;
            end else begin
              rem                     <= '0;
              work.seg[j].start       <= cur_seg.start + rem[23:0];
              work.seg[j].remaining   <= cur_seg.remaining - rem[23:0];
            end
          end
          if (j == 2'd2) begin
            state <= S_CWB;
          end else begin
            j <= j + 2'd1;
          end
        end
        S_CWB: begin
          res.result_kind <= gsr_pkg::RES_DONE;
          res.leftover    <= rem;
          state           <= S_ONE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= gsr_pkg::SLOTS_CNT)
    else $error("ring holds more slots than it has");

  a_result_bound: assert property (@(posedge clk) disable iff (rst)
    n <= gsr_pkg::CNT_W'(gsr_pkg::MAX_RESULTS))
    else $error("result count exceeds the per-request limit");

  a_idle_no_held: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !held_valid)
    else $error("held segment left behind at idle");

  a_offer_grows: assert property (@(posedge clk) disable iff (rst)
    state == S_O3 |=> pending == $past(pending) + (gsr_pkg::PTR_W + 1)'(1))
    else $error("offer did not add exactly one slot");

endmodule

### design/gather_segment_send_ring.sv
// Gather segment send ring: a transmit slot ring of header, control and data segments.
// Each request passes through a two-deep request queue into a slot engine that holds the
// slots in one RAM of RING_SLOTS words with registered read. An offer steps through
// O1, O2 and O3 (a full ring skips them); a clear moves the head to the tail; a gather
// walks pending slots within the result limit, with one step to check the walk, one for
// the RAM read and one for each of its three segments, one segment per cycle while the
// previous one can leave; a consume reads, sums and compares each slot, then releases it
// or trims its segments in order and writes it back. Results leave through an output
// register, and the engine waits while that register is full and not taken.
module gather_segment_send_ring (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [15:0] frame_tag,
  input  logic [31:0] bytes_sent,
  input  logic [23:0] control_len,
  input  logic [23:0] data_len,
  input  logic [31:0] written_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  result_kind,
  output logic [15:0] tag,
  output logic [1:0]  segment_kind,
  output logic [23:0] segment_start,
  output logic [23:0] segment_len,
  output logic [31:0] leftover,
  output logic        last
);

  gsr_pkg::req_t in_req;
  gsr_pkg::req_t q_req;
  gsr_pkg::res_t res;
  logic          q_valid;
  logic          q_take;

  always_comb begin
    in_req.mode          = mode;
    in_req.frame_tag     = frame_tag;
    in_req.bytes_sent    = bytes_sent;
    in_req.control_len   = control_len;
    in_req.data_len      = data_len;
    in_req.written_bytes = written_bytes;
  end

  gsr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .req_valid(q_valid),
    .req_take (q_take),
    .req      (q_req)
  );

  gsr_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .req_valid(q_valid),
    .req_take (q_take),
    .req_in   (q_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (res)
  );

  assign result_kind   = res.result_kind;
  assign tag           = res.tag;
  assign segment_kind  = res.segment_kind;
  assign segment_start = res.segment_start;
  assign segment_len   = res.segment_len;
  assign leftover      = res.leftover;
  assign last          = res.last;

endmodule

### tb/gather_segment_send_ring_tb.sv
// Self-checking testbench of the gather segment send ring, with its own ring predictor.
`timescale 1ns / 1ps

module gather_segment_send_ring_tb;
  import gsr_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = MODE_OFFER;
  logic [15:0] frame_tag = '0;
  logic [31:0] bytes_sent = '0;
  logic [23:0] control_len = '0;
  logic [23:0] data_len = '0;
  logic [31:0] written_bytes = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  result_kind;
  logic [15:0] tag;
  logic [1:0]  segment_kind;
  logic [23:0] segment_start;
  logic [23:0] segment_len;
  logic [31:0] leftover;
  logic        last;

  gather_segment_send_ring DUT (.*);

  // Predicted ring contents.
  logic [15:0] ring_tag [RING_SLOTS];
  logic [23:0] ring_start [3*RING_SLOTS];
  logic [23:0] ring_unsent [3*RING_SLOTS];
  int          ring_head = 0;
  int          ring_tail = 0;

  res_t expected_results [$];
  int   error_count = 0;
  int   results_checked = 0;
  int   requests_per_mode [4] = '{0, 0, 0, 0};
  int   cycle_count = 0;
  bit   no_stalls = 1'b0;
  int   out_stall = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int slots_pending();
    return (ring_tail - ring_head + 2*RING_SLOTS) % (2*RING_SLOTS);
  endfunction

  task automatic push_result(logic [2:0] kind, logic [15:0] t, logic [1:0] sk,
                             logic [23:0] st, logic [23:0] ln, logic [31:0] lo, logic lst);
    res_t r;
    r.result_kind = kind; r.tag = t; r.segment_kind = sk; r.segment_start = st;
    r.segment_len = ln; r.leftover = lo; r.last = lst;
    expected_results.push_back(r);
  endtask

  task automatic place_segment(int e, longint unsigned off, longint unsigned len);
    if (off < len) begin
      ring_start[e]  = off[23:0];
      ring_unsent[e] = 24'(len - off);
    end else begin
      ring_start[e]  = '0;
      ring_unsent[e] = '0;
    end
  endtask

  task automatic predict_request(req_t r);
    longint unsigned sent, clen, rem, total;
    int s, n, p, e;
    sent = r.bytes_sent;
    clen = r.control_len;
    n = 0;
    case (r.mode)
      MODE_OFFER: begin
        if (slots_pending() >= RING_SLOTS) begin
          push_result(RES_FULL, r.frame_tag, 2'd0, '0, '0, '0, 1'b1);
        end else begin
          s = ring_tail % RING_SLOTS;
          ring_tag[s] = r.frame_tag;
          place_segment(3*s, sent, HEADER_BYTES);
          place_segment(3*s + 1, (sent > HEADER_BYTES) ? sent - HEADER_BYTES : 0, clen);
          place_segment(3*s + 2, (sent > HEADER_BYTES + clen) ?
                        sent - HEADER_BYTES - clen : 0, r.data_len);
          ring_tail = (ring_tail + 1) % (2*RING_SLOTS);
          push_result(RES_ACCEPTED, r.frame_tag, 2'd0, '0, '0, '0, 1'b1);
        end
      end
      MODE_GATHER: begin
        p = ring_head;
        while (p != ring_tail && n + 3 <= MAX_RESULTS) begin
          s = p % RING_SLOTS;
          for (int j = 0; j < 3; j++) begin
            e = 3*s + j;
            if (ring_unsent[e] != 0) begin
              push_result(RES_SEGMENT, ring_tag[s], 2'(j), ring_start[e], ring_unsent[e],
                          '0, 1'b0);
              n++;
            end
          end
          p = (p + 1) % (2*RING_SLOTS);
        end
        if (n == 0) begin
          ring_head = ring_tail;
          push_result(RES_EMPTY, '0, 2'd0, '0, '0, '0, 1'b1);
        end else begin
          expected_results[$].last = 1'b1;
        end
      end
      MODE_CONSUME: begin
        rem = r.written_bytes;
        while (rem > 0 && ring_head != ring_tail && n < MAX_RESULTS - 1) begin
          s = ring_head % RING_SLOTS;
          total = longint'(ring_unsent[3*s]) + ring_unsent[3*s + 1] + ring_unsent[3*s + 2];
          if (rem >= total) begin
            rem -= total;
            for (int j = 0; j < 3; j++) ring_unsent[3*s + j] = '0;
            push_result(RES_RELEASED, ring_tag[s], 2'd0, '0, '0, '0, 1'b0);
            n++;
            ring_head = (ring_head + 1) % (2*RING_SLOTS);
          end else begin
            for (int j = 0; j < 3 && rem > 0; j++) begin
              e = 3*s + j;
              if (ring_unsent[e] <= rem) begin
                rem -= ring_unsent[e];
                ring_start[e]  = ring_start[e] + ring_unsent[e];
                ring_unsent[e] = '0;
              end else begin
                ring_start[e]  = ring_start[e] + 24'(rem);
                ring_unsent[e] = ring_unsent[e] - 24'(rem);
                rem = 0;
              end
            end
            break;
          end
        end
        push_result(RES_DONE, '0, 2'd0, '0, '0, 32'(rem), 1'b1);
      end
      default: begin
        ring_head = ring_tail;
        push_result(RES_DONE, '0, 2'd0, '0, '0, '0, 1'b1);
      end
    endcase
  endtask

  // Sends one request; the gap before it is random unless stalls are switched off.
  task automatic send_request(logic [1:0] m, logic [15:0] ft, logic [31:0] so,
                              logic [23:0] cl, logic [23:0] dl, logic [31:0] wb);
    req_t r;
    int gap;
    gap = no_stalls ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mode <= m; frame_tag <= ft; bytes_sent <= so;
    control_len <= cl; data_len <= dl; written_bytes <= wb;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    r.mode = m; r.frame_tag = ft; r.bytes_sent = so;
    r.control_len = cl; r.data_len = dl; r.written_bytes = wb;
    predict_request(r);
    requests_per_mode[m]++;
  endtask

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result_kind: expected none, got %0d", result_kind);
          error_count++;
        end else begin
          e = expected_results.pop_front();
          check_field("result_kind", 32'(e.result_kind), 32'(result_kind));
          check_field("tag", 32'(e.tag), 32'(tag));
          check_field("segment_kind", 32'(e.segment_kind), 32'(segment_kind));
          check_field("segment_start", 32'(e.segment_start), 32'(segment_start));
          check_field("segment_len", 32'(e.segment_len), 32'(segment_len));
          check_field("leftover", e.leftover, leftover);
          check_field("last", 32'(e.last), 32'(last));
          results_checked++;
        end
        out_stall = no_stalls ? 0 : $urandom_range(0, 10);
      end
      if (out_stall > 0 && !(out_valid && out_ready)) out_stall--;
      out_ready <= (out_stall == 0);
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_ring();
    send_request(MODE_GATHER, 16'h1234, '0, '0, '0, '0);
    send_request(MODE_CONSUME, '0, '0, '0, '0, 32'd5);
    send_request(MODE_CONSUME, '0, '0, '0, '0, '0);
    send_request(MODE_CLEAR, '0, '0, '0, '0, '0);
  endtask

  // Fills the ring with edge-case offers, hits the full ring, then gathers the whole ring and consumes from it.
  task automatic test_full_ring();
    logic [31:0] sents [8] = '{0, 15, 16, 17, 'hFFFF_FFFF, 40, 1, 'h00FF_FFFF};
    for (int i = 0; i < RING_SLOTS; i++)
      send_request(MODE_OFFER, (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'(i),
                   (i < 8) ? sents[i] : '0, (i % 3 == 0) ? 24'hFF_FFFF : 24'(i + 1),
                   (i % 4 == 1) ? 24'hFF_FFFF : 24'(i), '0);
    send_request(MODE_OFFER, 16'hBEEF, '0, 24'd3, 24'd3, '0);
    send_request(MODE_GATHER, '0, '0, '0, '0, '0);
    send_request(MODE_CONSUME, '0, '0, '0, '0, 32'd20);
    send_request(MODE_CONSUME, '0, '0, '0, '0, 32'hFFFF_FFFF);
  endtask

  task automatic test_drop_idle_slots();
    // A frame already sent in full leaves a slot with nothing to send; gather drops it.
    send_request(MODE_OFFER, 16'hA5A5, 32'd100, 24'd10, 24'd20, '0);
    send_request(MODE_GATHER, '0, '0, '0, '0, '0);
    send_request(MODE_OFFER, 16'h5A5A, 32'd100, 24'd10, 24'd20, '0);
    send_request(MODE_CONSUME, '0, '0, '0, '0, 32'd7);
  endtask

  task automatic test_random_traffic(int count);
    int pick;
    logic [31:0] so, wb;
    logic [23:0] cl, dl;
    for (int i = 0; i < count; i++) begin
      no_stalls = (i >= count/3 && i < count/3 + 20);
      pick = $urandom_range(0, 99);
      so = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);
      cl = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 30));
      dl = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 80));
      wb = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 150);
      if (i == count/2) begin
        // Let the block go completely quiet before carrying on.
        wait_drained();
        repeat ($urandom_range(5, 30)) @(posedge clk);
      end
      send_request((pick < 50) ? MODE_OFFER : (pick < 70) ? MODE_GATHER :
                   (pick < 96) ? MODE_CONSUME : MODE_CLEAR,
                   16'($urandom), so, cl, dl, wb);
    end
    no_stalls = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_ring();
    test_full_ring();
    test_drop_idle_slots();
    test_random_traffic(132);
    wait_drained();
    repeat (100) @(posedge clk);
    $display("Requests sent: %0d offers, %0d gathers, %0d consumes, %0d clears.",
             requests_per_mode[0], requests_per_mode[1], requests_per_mode[2],
             requests_per_mode[3]);
    $display("Results compared against the predictor: %0d.", results_checked);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
